FILE: hdl/dau_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dau_pkg
// Shared constants, register map and arctangent table of the dihedral unit.
// ----------------------------------------------------------------------------
package dau_pkg;

  localparam int COORD_WIDTH_DEF = 20;

  // register port
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam int LIMIT_W = 32;
  typedef logic [ADDR_W-3:0] reg_idx_t;
  localparam reg_idx_t REG_DEGENERATE_LIMIT = '0;

  // multiplier slicing
  localparam int MUL_CHUNK = 24;

  // fixed-point formats
  localparam int SQRT_PAD = 32;   // |b2|^2 scaled by 2^32 before the root
  localparam int Y_SHIFT = 16;    // y term scaled by 2^16
  localparam int NORM_BITS = 30;  // normalized magnitude width
  localparam int SEG_W = 16;      // leading-one search segment
  localparam int LOC_W = 5;

  // CORDIC
  localparam int CORDIC_STEPS = 23;
  localparam int CW = 34;         // x/y datapath
  localparam int ZW = 26;         // angle accumulator, 1/65536 degree
  localparam int HALF_TURN = 180 * 65536;
  localparam int ROUND_BIAS = 256;
  localparam int ROUND_SHIFT = 9;
  localparam int ANGLE_W = 16;
  localparam int ANGLE_MAX = 23040;

  localparam int ATAN_TAB [CORDIC_STEPS] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1
  };

endpackage
`default_nettype wire

FILE: hdl/dau_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dau_mul
// Three-stage signed multiplier: sliced partial products, row sums, final sum.
// ----------------------------------------------------------------------------
module dau_mul #(
  parameter int AW = dau_pkg::COORD_WIDTH_DEF + 1,
  parameter int BW = dau_pkg::COORD_WIDTH_DEF + 1
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [AW-1:0]     a,
  input  logic signed [BW-1:0]     b,
  output logic signed [AW+BW-1:0]  p
);
  import dau_pkg::*;

  localparam int NA = (AW + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int CA = (AW + NA - 1) / NA;
  localparam int NB = (BW + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int CB = (BW + NB - 1) / NB;
  localparam int PPW = CA + CB + 2;
  localparam int FW = NA * CA + NB * CB + 2;

  logic signed [NA*CA-1:0] apad;
  logic signed [NB*CB-1:0] bpad;
  logic signed [PPW-1:0]   pp_c [NA][NB];
  logic signed [PPW-1:0]   pp   [NA][NB];
  logic signed [FW-1:0]    row_c [NB];
  logic signed [FW-1:0]    row   [NB];
  logic signed [FW-1:0]    sum_c;

  assign apad = (NA*CA)'(a);
  assign bpad = (NB*CB)'(b);

  // top slice signed, lower slices unsigned
  always_comb begin
    logic signed [CA:0] ea;
    logic signed [CB:0] eb;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        ea = (i == NA - 1) ? {apad[i*CA+CA-1], apad[i*CA +: CA]} : {1'b0, apad[i*CA +: CA]};
        eb = (j == NB - 1) ? {bpad[j*CB+CB-1], bpad[j*CB +: CB]} : {1'b0, bpad[j*CB +: CB]};
        pp_c[i][j] = ea * eb;
      end
    end
  end

  always_comb begin
    logic signed [FW-1:0] acc;
    for (int j = 0; j < NB; j++) begin
      acc = '0;
      for (int i = 0; i < NA; i++) begin
        acc = acc + (FW'(pp[i][j]) <<< (i * CA));
      end
      row_c[j] = acc;
    end
  end

  always_comb begin
    sum_c = '0;
    for (int j = 0; j < NB; j++) begin
      sum_c = sum_c + (row[j] <<< (j * CB));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp  <= pp_c;
      row <= row_c;
      p   <= sum_c[AW+BW-1:0];
    end
  end

endmodule
`default_nettype wire

FILE: hdl/dihedral_angle_unit_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one item per cycle unless stalled; fully stage-registered pipeline.
// Depth is set by the square-root pipeline, one root bit per stage (COORD_WIDTH+18).
// Reset (rst, synchronous) clears the valid bits, the skid stage and
// degenerate_limit (to 0). No clearing pass is needed.
// ----------------------------------------------------------------------------
// dihedral_angle_unit_top
// Torsion angle of four points: bond vectors, normals, dot/cross terms,
// |b2| by square root, wide X/Y normalization, then a 23-step CORDIC.
// ----------------------------------------------------------------------------
module dihedral_angle_unit_top #(
  parameter int COORD_WIDTH = dau_pkg::COORD_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // register port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [dau_pkg::ADDR_W-1:0]         paddr,
  input  logic [dau_pkg::DATA_W-1:0]         pwdata,
  output logic [dau_pkg::DATA_W-1:0]         prdata,
  output logic                               pready,
  // input items
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [COORD_WIDTH-1:0]      ax,
  input  logic signed [COORD_WIDTH-1:0]      ay,
  input  logic signed [COORD_WIDTH-1:0]      az,
  input  logic signed [COORD_WIDTH-1:0]      bx,
  input  logic signed [COORD_WIDTH-1:0]      by,
  input  logic signed [COORD_WIDTH-1:0]      bz,
  input  logic signed [COORD_WIDTH-1:0]      cx,
  input  logic signed [COORD_WIDTH-1:0]      cy,
  input  logic signed [COORD_WIDTH-1:0]      cz,
  input  logic signed [COORD_WIDTH-1:0]      dx,
  input  logic signed [COORD_WIDTH-1:0]      dy,
  input  logic signed [COORD_WIDTH-1:0]      dz,
  // result items
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [dau_pkg::ANGLE_W-1:0] angle,
  output logic                               degenerate
);
  import dau_pkg::*;

  // widths, all exact
  localparam int BW  = COORD_WIDTH + 1;        // bond vector
  localparam int NW  = 2 * BW + 1;             // normal component
  localparam int VW  = 2 * BW + 2;             // |b2|^2
  localparam int SW  = (VW + SQRT_PAD) / 2;    // root of |b2|^2 * 2^32
  localparam int RW  = SW + 3;                 // root remainder
  localparam int LW  = 2 * NW + 2;             // |n|^2 and n1.n2
  localparam int MW  = NW + BW + 1;            // n1 x b2
  localparam int YW  = MW + NW + 2;            // (n1 x b2).n2
  localparam int YNW = YW + 1;                 // negated
  localparam int PW  = SW + 1 + LW;            // X and Y before normalizing
  localparam int LBW = $clog2(PW + 1);
  localparam int NSEG = (PW + SEG_W - 1) / SEG_W;
  // alignment delays
  localparam int DDN = SW - 4;                 // n1.n2 waits for the root
  localparam int YDN = SW - 5;                 // Y waits for X
  localparam int GDN = SW + 26;                // degenerate flag to the last stage
  localparam int TOT = SW + 37;                // pipeline stages

  // --------------------------------------------------------------------------
  // Register port
  // --------------------------------------------------------------------------
  logic [LIMIT_W-1:0] limit;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= '0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[ADDR_W-1:2] == REG_DEGENERATE_LIMIT) begin
      limit <= pwdata[LIMIT_W-1:0];
    end
  end

  always_comb begin
    unique case (paddr[ADDR_W-1:2])
      REG_DEGENERATE_LIMIT: prdata = DATA_W'(limit);
      default:              prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Flow control: the whole pipeline advances unless the skid stage holds an
  // item. An item leaving the last stage goes to the output register, or to
  // the skid stage when the output is stalled; the next cycle then freezes.
  // --------------------------------------------------------------------------
  logic en;
  logic skid_vld;
  logic vld [TOT];

  assign en       = !skid_vld;
  assign in_stall = skid_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TOT; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int i = 1; i < TOT; i++) vld[i] <= vld[i-1];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: bond vectors
  // --------------------------------------------------------------------------
  logic signed [BW-1:0] b1 [3];
  logic signed [BW-1:0] b2 [3];
  logic signed [BW-1:0] b3 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      b1[0] <= BW'(bx) - BW'(ax);
      b1[1] <= BW'(by) - BW'(ay);
      b1[2] <= BW'(bz) - BW'(az);
      b2[0] <= BW'(cx) - BW'(bx);
      b2[1] <= BW'(cy) - BW'(by);
      b2[2] <= BW'(cz) - BW'(bz);
      b3[0] <= BW'(dx) - BW'(cx);
      b3[1] <= BW'(dy) - BW'(cy);
      b3[2] <= BW'(dz) - BW'(cz);
    end
  end

  // --------------------------------------------------------------------------
  // Stages 2-5: normals n1 = b1 x b2, n2 = b2 x b3, and |b2|^2
  // --------------------------------------------------------------------------
  logic signed [2*BW-1:0] n1p [3];
  logic signed [2*BW-1:0] n1q [3];
  logic signed [2*BW-1:0] n2p [3];
  logic signed [2*BW-1:0] n2q [3];
  logic signed [2*BW-1:0] b2sq [3];

  for (genvar k = 0; k < 3; k++) begin : g_normal
    localparam int I1 = (k + 1) % 3;
    localparam int I2 = (k + 2) % 3;
    dau_mul #(.AW(BW), .BW(BW)) u_n1p (.clk, .en, .a(b1[I1]), .b(b2[I2]), .p(n1p[k]));
    dau_mul #(.AW(BW), .BW(BW)) u_n1q (.clk, .en, .a(b1[I2]), .b(b2[I1]), .p(n1q[k]));
    dau_mul #(.AW(BW), .BW(BW)) u_n2p (.clk, .en, .a(b2[I1]), .b(b3[I2]), .p(n2p[k]));
    dau_mul #(.AW(BW), .BW(BW)) u_n2q (.clk, .en, .a(b2[I2]), .b(b3[I1]), .p(n2q[k]));
    dau_mul #(.AW(BW), .BW(BW)) u_sq  (.clk, .en, .a(b2[k]),  .b(b2[k]),  .p(b2sq[k]));
  end

  logic signed [BW-1:0] b2d [4][3];
  logic signed [NW-1:0] n1 [3];
  logic signed [NW-1:0] n2 [3];
  logic [VW-1:0]        vsq;

  always_ff @(posedge clk) begin
    if (en) begin
      b2d[0] <= b2;
      for (int i = 1; i < 4; i++) b2d[i] <= b2d[i-1];
      for (int k = 0; k < 3; k++) begin
        n1[k] <= NW'(n1p[k]) - NW'(n1q[k]);
        n2[k] <= NW'(n2p[k]) - NW'(n2q[k]);
      end
      vsq <= VW'(b2sq[0]) + VW'(b2sq[1]) + VW'(b2sq[2]);
    end
  end

  // --------------------------------------------------------------------------
  // Stages 6-9: |n1|^2, |n2|^2, n1.n2 and m = n1 x b2
  // --------------------------------------------------------------------------
  logic signed [2*NW-1:0]   l1p [3];
  logic signed [2*NW-1:0]   l2p [3];
  logic signed [2*NW-1:0]   dp  [3];
  logic signed [NW+BW-1:0]  mp  [3];
  logic signed [NW+BW-1:0]  mq  [3];

  for (genvar k = 0; k < 3; k++) begin : g_dot
    localparam int I1 = (k + 1) % 3;
    localparam int I2 = (k + 2) % 3;
    dau_mul #(.AW(NW), .BW(NW)) u_l1 (.clk, .en, .a(n1[k]), .b(n1[k]), .p(l1p[k]));
    dau_mul #(.AW(NW), .BW(NW)) u_l2 (.clk, .en, .a(n2[k]), .b(n2[k]), .p(l2p[k]));
    dau_mul #(.AW(NW), .BW(NW)) u_d  (.clk, .en, .a(n1[k]), .b(n2[k]), .p(dp[k]));
    dau_mul #(.AW(NW), .BW(BW)) u_mp (.clk, .en, .a(n1[I1]), .b(b2d[3][I2]), .p(mp[k]));
    dau_mul #(.AW(NW), .BW(BW)) u_mq (.clk, .en, .a(n1[I2]), .b(b2d[3][I1]), .p(mq[k]));
  end

  logic signed [NW-1:0] n2d [4][3];
  logic [LW-1:0]        l1s;
  logic [LW-1:0]        l2s;
  logic signed [LW-1:0] dsum;
  logic signed [MW-1:0] m [3];

  always_ff @(posedge clk) begin
    if (en) begin
      n2d[0] <= n2;
      for (int i = 1; i < 4; i++) n2d[i] <= n2d[i-1];
      l1s  <= LW'(l1p[0]) + LW'(l1p[1]) + LW'(l1p[2]);
      l2s  <= LW'(l2p[0]) + LW'(l2p[1]) + LW'(l2p[2]);
      dsum <= LW'(dp[0]) + LW'(dp[1]) + LW'(dp[2]);
      for (int k = 0; k < 3; k++) m[k] <= MW'(mp[k]) - MW'(mq[k]);
    end
  end

  // --------------------------------------------------------------------------
  // Stages 10-13: Y = -(m.n2); degenerate test at stage 10
  // --------------------------------------------------------------------------
  logic signed [MW+NW-1:0] yp [3];

  for (genvar k = 0; k < 3; k++) begin : g_ydot
    dau_mul #(.AW(MW), .BW(NW)) u_y (.clk, .en, .a(m[k]), .b(n2d[3][k]), .p(yp[k]));
  end

  logic signed [YNW-1:0] yneg;
  logic                  deg0;

  always_ff @(posedge clk) begin
    if (en) begin
      deg0 <= (l1s <= LW'(limit)) || (l2s <= LW'(limit));
      yneg <= -(YNW'(yp[0]) + YNW'(yp[1]) + YNW'(yp[2]));
    end
  end

  // --------------------------------------------------------------------------
  // Square root of |b2|^2 * 2^32, one root bit per stage (stages 6..5+SW).
  // Remaining radicand bits shift out of the top two at a time; the low
  // 2^32 padding enters as zeros.
  // --------------------------------------------------------------------------
  logic [RW-1:0] sq_rem  [SW];
  logic [SW-1:0] sq_root [SW];
  logic [VW-1:0] sq_rest [SW];

  for (genvar k = 0; k < SW; k++) begin : g_sqrt
    logic [RW-1:0] rin;
    logic [SW-1:0] qin;
    logic [VW-1:0] vin;
    logic [RW-1:0] r2;
    logic [RW-1:0] trial;
    logic          take;

    if (k == 0) begin : g_first
      assign rin = '0;
      assign qin = '0;
      assign vin = vsq;
    end else begin : g_next
      assign rin = sq_rem[k-1];
      assign qin = sq_root[k-1];
      assign vin = sq_rest[k-1];
    end

    assign r2    = {rin[RW-3:0], vin[VW-1 -: 2]};
    assign trial = RW'({qin, 2'b01});
    assign take  = (r2 >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        sq_rem[k]  <= take ? (r2 - trial) : r2;
        sq_root[k] <= {qin[SW-2:0], take};
        sq_rest[k] <= vin << 2;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Alignment delays and X = |b2| * (n1.n2)
  // --------------------------------------------------------------------------
  logic signed [LW-1:0]  dd [DDN];
  logic signed [YNW-1:0] yd [YDN];
  logic                  gd [GDN];

  always_ff @(posedge clk) begin
    if (en) begin
      dd[0] <= dsum;
      for (int i = 1; i < DDN; i++) dd[i] <= dd[i-1];
      yd[0] <= yneg;
      for (int i = 1; i < YDN; i++) yd[i] <= yd[i-1];
      gd[0] <= deg0;
      for (int i = 1; i < GDN; i++) gd[i] <= gd[i-1];
    end
  end

  logic signed [SW:0]   root_s;
  logic signed [PW-1:0] xp;

  assign root_s = {1'b0, sq_root[SW-1]};

  dau_mul #(.AW(SW + 1), .BW(LW)) u_x (.clk, .en, .a(root_s), .b(dd[DDN-1]), .p(xp));

  // --------------------------------------------------------------------------
  // Normalization: magnitudes, leading-one search in two steps, common shift
  // so the larger magnitude has exactly NORM_BITS bits.
  // --------------------------------------------------------------------------
  logic signed [PW-1:0] yext;
  logic signed [PW-1:0] nx1, ny1, nx2, ny2, nx3, ny3;
  logic [PW-1:0]        mag_or;
  logic [NSEG*SEG_W-1:0] mag_pad;
  logic                 seg_nz_c [NSEG];
  logic [LOC_W-1:0]     seg_loc_c [NSEG];
  logic                 seg_nz [NSEG];
  logic [LOC_W-1:0]     seg_loc [NSEG];
  logic [LBW-1:0]       blen_c;
  logic [LBW-1:0]       blen;
  logic signed [PW-1:0] xsh, ysh;
  logic signed [CW-1:0] x0, y0;

  assign yext    = PW'(yd[YDN-1]) <<< Y_SHIFT;
  assign mag_pad = (NSEG*SEG_W)'(mag_or);

  always_comb begin
    for (int s = 0; s < NSEG; s++) begin
      seg_nz_c[s]  = |mag_pad[s*SEG_W +: SEG_W];
      seg_loc_c[s] = '0;
      for (int j = 0; j < SEG_W; j++) begin
        if (mag_pad[s*SEG_W + j]) seg_loc_c[s] = LOC_W'(j + 1);
      end
    end
  end

  always_comb begin
    blen_c = '0;
    for (int s = 0; s < NSEG; s++) begin
      if (seg_nz[s]) blen_c = LBW'(s * SEG_W) + LBW'(seg_loc[s]);
    end
  end

  always_comb begin
    xsh = nx3 >>> (blen - LBW'(NORM_BITS));
    ysh = ny3 >>> (blen - LBW'(NORM_BITS));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nx1    <= xp;
      ny1    <= yext;
      mag_or <= (xp[PW-1] ? PW'(-xp) : PW'(xp)) | (yext[PW-1] ? PW'(-yext) : PW'(yext));
      nx2     <= nx1;
      ny2     <= ny1;
      seg_nz  <= seg_nz_c;
      seg_loc <= seg_loc_c;
      nx3  <= nx2;
      ny3  <= ny2;
      blen <= blen_c;
      if (blen > LBW'(NORM_BITS)) begin
        x0 <= xsh[CW-1:0];
        y0 <= ysh[CW-1:0];
      end else begin
        x0 <= nx3[CW-1:0] <<< (LBW'(NORM_BITS) - blen);
        y0 <= ny3[CW-1:0] <<< (LBW'(NORM_BITS) - blen);
      end
    end
  end

  // --------------------------------------------------------------------------
  // CORDIC: fold the left half-plane, then one vectoring step per stage
  // --------------------------------------------------------------------------
  logic signed [CW-1:0] rx, ry;
  logic signed [ZW-1:0] rz;

  always_ff @(posedge clk) begin
    if (en) begin
      if (x0 < 0) begin
        rx <= -x0;
        ry <= -y0;
        rz <= (y0 >= 0) ? ZW'(HALF_TURN) : -ZW'(HALF_TURN);
      end else begin
        rx <= x0;
        ry <= y0;
        rz <= '0;
      end
    end
  end

  logic signed [CW-1:0] crx [CORDIC_STEPS];
  logic signed [CW-1:0] cry [CORDIC_STEPS];
  logic signed [ZW-1:0] crz [CORDIC_STEPS];

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    logic signed [CW-1:0] xi, yi;
    logic signed [ZW-1:0] zi;

    if (k == 0) begin : g_first
      assign xi = rx;
      assign yi = ry;
      assign zi = rz;
    end else begin : g_next
      assign xi = crx[k-1];
      assign yi = cry[k-1];
      assign zi = crz[k-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (yi > 0) begin
          crx[k] <= xi + (yi >>> k);
          cry[k] <= yi - (xi >>> k);
          crz[k] <= zi + ZW'(ATAN_TAB[k]);
        end else begin
          crx[k] <= xi - (yi >>> k);
          cry[k] <= yi + (xi >>> k);
          crz[k] <= zi - ZW'(ATAN_TAB[k]);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Last stage: round to 1/128 degree, clamp, force zero when degenerate
  // --------------------------------------------------------------------------
  logic signed [ZW-1:0]      zr;
  logic signed [ANGLE_W-1:0] fin_angle;
  logic                      fin_deg;

  assign zr = (crz[CORDIC_STEPS-1] + ZW'(ROUND_BIAS)) >>> ROUND_SHIFT;

  always_ff @(posedge clk) begin
    if (en) begin
      fin_deg <= gd[GDN-1];
      if (gd[GDN-1]) begin
        fin_angle <= '0;
      end else if (zr > ZW'(ANGLE_MAX)) begin
        fin_angle <= ANGLE_W'(ANGLE_MAX);
      end else if (zr < -ZW'(ANGLE_MAX)) begin
        fin_angle <= -ANGLE_W'(ANGLE_MAX);
      end else begin
        fin_angle <= zr[ANGLE_W-1:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register and skid stage
  // --------------------------------------------------------------------------
  logic                      push;
  logic                      take_out;
  logic signed [ANGLE_W-1:0] skid_angle;
  logic                      skid_deg;

  assign push     = en && vld[TOT-1];
  assign take_out = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_vld  <= 1'b0;
    end else if (skid_vld) begin
      if (take_out) begin
        skid_vld <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !take_out) begin
        skid_vld <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (take_out) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld) begin
      if (take_out) begin
        angle      <= skid_angle;
        degenerate <= skid_deg;
      end
    end else if (push) begin
      if (out_valid && !take_out) begin
        skid_angle <= fin_angle;
        skid_deg   <= fin_deg;
      end else begin
        angle      <= fin_angle;
        degenerate <= fin_deg;
      end
    end
  end

`ifndef ASSERT_OFF
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_vld |-> out_valid) else $error("skid holds an item while output is empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_vld) |-> $past(out_valid && out_stall))
    else $error("skid filled without a stalled output");

  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && degenerate) |-> (angle == '0))
    else $error("degenerate item with nonzero angle");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (angle <= ANGLE_W'(ANGLE_MAX) && angle >= -ANGLE_W'(ANGLE_MAX)))
    else $error("angle out of range");
`endif

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the dihedral angle unit. Point quadruples go in
// through the valid/stall port with random gaps; a bit-exact torsion-angle
// predictor (wide integer normals, root, normalization, CORDIC) forms the
// expected angle and degenerate flag, matched in order against the results
// under random output stalls. The degenerate limit is swept over several
// values, extremes included, through the register port between phases.
// ----------------------------------------------------------------------------
module tb_top;
  import dau_pkg::*;

  localparam int CW_IN = COORD_WIDTH_DEF;
  localparam int C_MAX = 524287;
  localparam int C_MIN = -524288;
  localparam int LATENCY = CW_IN + 56;

  typedef logic signed [255:0] wide_t;
  typedef logic signed [CW_IN-1:0] coord_t;

  typedef struct {
    logic signed [ANGLE_W-1:0] angle;
    logic                      degenerate;
  } torsion_t;

  // One directed row: twelve coordinates A..D (x,y,z), plus a typed-in
  // result where it is obvious (degenerate geometry).
  typedef struct {
    int       c[12];
    bit       typed;
    torsion_t res;
  } quad_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0]     paddr = '0;
  logic [DATA_W-1:0]     pwdata = '0;
  logic [DATA_W-1:0]     prdata;
  logic                  pready;

  logic   in_valid = 1'b0;
  logic   in_stall;
  coord_t pt [12];
  logic   out_valid;
  logic   out_stall = 1'b0;
  logic signed [ANGLE_W-1:0] angle;
  logic   degenerate;

  torsion_t angle_due_q [$];
  logic [LIMIT_W-1:0] limit_now = '0;  // mirror of degenerate_limit
  int  mismatches = 0;
  bit  steady = 1'b0;                  // no gaps, no stalls while set

  initial begin
    foreach (pt[i]) pt[i] = '0;
  end

  dihedral_angle_unit_top #(.COORD_WIDTH(CW_IN)) i_dut (
    .clk, .rst,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_stall,
    .ax(pt[0]), .ay(pt[1]), .az(pt[2]),
    .bx(pt[3]), .by(pt[4]), .bz(pt[5]),
    .cx(pt[6]), .cy(pt[7]), .cz(pt[8]),
    .dx(pt[9]), .dy(pt[10]), .dz(pt[11]),
    .out_valid, .out_stall, .angle, .degenerate
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #5ms;
    $display("tb_top: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor. All intermediates fit easily in 256 bits (worst is ~125 bits).
  // ---------------------------------------------------------------------------
  function automatic void cross_w(input wide_t a[3], input wide_t b[3],
                                  output wide_t r[3]);
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  function automatic wide_t dot_w(input wide_t a[3], input wide_t b[3]);
    return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
  endfunction

  function automatic int bit_len(input wide_t v);
    for (int i = 255; i >= 0; i--)
      if (v[i]) return i + 1;
    return 0;
  endfunction

  // floor(sqrt(n)), bit-pair method
  function automatic wide_t floor_root(input wide_t n);
    wide_t rem, res, one_bit;
    int    l;
    rem = n;
    res = '0;
    l = bit_len(n);
    if (l == 0) return '0;
    one_bit = wide_t'(1) << ((l - 1) & ~1);
    while (one_bit != 0) begin
      if (rem >= res + one_bit) begin
        rem = rem - (res + one_bit);
        res = (res >> 1) + one_bit;
      end else begin
        res = res >> 1;
      end
      one_bit = one_bit >> 2;
    end
    return res;
  endfunction

  function automatic torsion_t torsion_predict(input coord_t c[12],
                                               input logic [LIMIT_W-1:0] lim);
    wide_t    b1[3], b2[3], b3[3], n1[3], n2[3], m[3];
    wide_t    l1, l2, s, xw, yw, xa, ya;
    longint   x, y, z, xs, ys, r;
    int       l;
    torsion_t t;
    for (int i = 0; i < 3; i++) begin
      b1[i] = wide_t'(c[3 + i]) - wide_t'(c[i]);
      b2[i] = wide_t'(c[6 + i]) - wide_t'(c[3 + i]);
      b3[i] = wide_t'(c[9 + i]) - wide_t'(c[6 + i]);
    end
    cross_w(b1, b2, n1);
    cross_w(b2, b3, n2);
    l1 = dot_w(n1, n1);
    l2 = dot_w(n2, n2);
    if (l1 <= wide_t'({1'b0, lim}) || l2 <= wide_t'({1'b0, lim})) begin
      t.angle = '0;
      t.degenerate = 1'b1;
      return t;
    end
    s = floor_root(dot_w(b2, b2) << 32);
    xw = s * dot_w(n1, n2);
    cross_w(n1, b2, m);
    yw = -dot_w(m, n2) <<< Y_SHIFT;
    // common shift so the larger magnitude is NORM_BITS wide
    xa = xw < 0 ? -xw : xw;
    ya = yw < 0 ? -yw : yw;
    l = bit_len(xa);
    if (bit_len(ya) > l) l = bit_len(ya);
    if (l > NORM_BITS) begin
      xw = xw >>> (l - NORM_BITS);
      yw = yw >>> (l - NORM_BITS);
    end else if (l > 0) begin
      xw = xw <<< (NORM_BITS - l);
      yw = yw <<< (NORM_BITS - l);
    end
    x = xw[63:0];
    y = yw[63:0];
    z = 0;
    // left half-plane: flip and start from +-180 deg
    if (x < 0) begin
      z = (y >= 0) ? longint'(HALF_TURN) : -longint'(HALF_TURN);
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += ATAN_TAB[i];
      end else begin
        x -= ys; y += xs; z -= ATAN_TAB[i];
      end
    end
    r = (z + ROUND_BIAS) >>> ROUND_SHIFT;
    if (r > ANGLE_MAX) r = ANGLE_MAX;
    if (r < -ANGLE_MAX) r = -ANGLE_MAX;
    t.angle = r[ANGLE_W-1:0];
    t.degenerate = 1'b0;
    return t;
  endfunction

  // ---------------------------------------------------------------------------
  // Register port: setup + access, then read back. Caller is at a posedge.
  // ---------------------------------------------------------------------------
  task automatic limit_write(input logic [LIMIT_W-1:0] v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {REG_DEGENERATE_LIMIT, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    limit_now = v;
    pwrite <= 1'b0; penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== v)
      $error("degenerate_limit readback: expected %h actual %h", v, prdata);
    psel <= 1'b0; penable <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Item driver. Valid stays up between back-to-back items; the payload is
  // only replaced after the accepting edge.
  // ---------------------------------------------------------------------------
  task automatic send_quad(input coord_t c[12]);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    foreach (pt[i]) pt[i] <= c[i];
    do @(posedge clk); while (in_stall);
    angle_due_q.insert(angle_due_q.size(), torsion_predict(c, limit_now));
  endtask

  // random quadruple, several shapes
  task automatic random_quad(output coord_t c[12]);
    int     shape, span;
    coord_t v[3];
    shape = $urandom_range(0, 9);
    span = (shape < 4) ? 0 : (shape < 6) ? 64 : (shape < 8) ? 4096 : 1 << 17;
    foreach (c[i])
      c[i] = (span == 0) ? coord_t'($urandom) : coord_t'($urandom_range(0, 2 * span) - span);
    // occasionally make A, B, C collinear or B == C (degenerate geometry)
    if ($urandom_range(0, 11) == 0) begin
      for (int i = 0; i < 3; i++) begin
        v[i] = coord_t'($urandom_range(0, 2000) - 1000);
        c[i] = coord_t'($urandom_range(0, 200000) - 100000);
        c[3 + i] = c[i] + v[i];
        c[6 + i] = c[3 + i] + ($urandom_range(0, 1) ? v[i] : coord_t'(0));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall per item, in-order compare.
  // ---------------------------------------------------------------------------
  int stall_left = 0;
  always @(posedge clk) begin
    torsion_t want;
    if (!rst && out_valid && !out_stall) begin
      if (angle_due_q.size() == 0) begin
        $error("result with nothing expected: angle %0d degenerate %0b", angle, degenerate);
        mismatches++;
      end else begin
        want = angle_due_q.pop_front();
        if (angle !== want.angle) begin
          $error("angle: expected %0d actual %0d", want.angle, angle);
          mismatches++;
        end
        if (degenerate !== want.degenerate) begin
          $error("degenerate: expected %0b actual %0b", want.degenerate, degenerate);
          mismatches++;
        end
      end
      stall_left = steady ? 0 : $urandom_range(0, 10);
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  quad_row_t rows [18];
  logic [LIMIT_W-1:0] limits [5];

  initial begin
    coord_t c[12];
    torsion_t deg0;
    deg0.angle = '0;
    deg0.degenerate = 1'b1;

    rows = '{
      // all zero, all max, all min: every normal vanishes
      '{'{0,0,0, 0,0,0, 0,0,0, 0,0,0}, 1'b1, deg0},
      '{'{C_MAX,C_MAX,C_MAX, C_MAX,C_MAX,C_MAX, C_MAX,C_MAX,C_MAX, C_MAX,C_MAX,C_MAX},
        1'b1, deg0},
      '{'{C_MIN,C_MIN,C_MIN, C_MIN,C_MIN,C_MIN, C_MIN,C_MIN,C_MIN, C_MIN,C_MIN,C_MIN},
        1'b1, deg0},
      // A, B, C on one line
      '{'{0,0,0, 256,0,0, 512,0,0, 512,256,0}, 1'b1, deg0},
      // zero middle bond
      '{'{0,0,0, 256,0,0, 256,0,0, 256,256,0}, 1'b1, deg0},
      // C, D coincide: second normal zero
      '{'{0,256,0, 0,0,0, 256,0,0, 256,0,0}, 1'b1, deg0},
      // cis, trans, +/-90, near +/-180
      '{'{0,256,0, 0,0,0, 256,0,0, 256,256,0}, 1'b0, deg0},
      '{'{0,256,0, 0,0,0, 256,0,0, 256,-256,0}, 1'b0, deg0},
      '{'{0,256,0, 0,0,0, 256,0,0, 256,0,256}, 1'b0, deg0},
      '{'{0,256,0, 0,0,0, 256,0,0, 256,0,-256}, 1'b0, deg0},
      '{'{0,256,0, 0,0,0, 256,0,0, 256,-256,1}, 1'b0, deg0},
      '{'{0,256,0, 0,0,0, 256,0,0, 256,-256,-1}, 1'b0, deg0},
      // coordinate extremes
      '{'{C_MIN,C_MIN,C_MIN, C_MAX,C_MIN,C_MAX, C_MAX,C_MAX,C_MIN, C_MIN,C_MAX,C_MAX},
        1'b0, deg0},
      '{'{C_MAX,0,0, 0,C_MAX,0, 0,0,C_MAX, C_MIN,C_MIN,C_MIN}, 1'b0, deg0},
      '{'{C_MIN,C_MAX,0, C_MAX,C_MIN,0, C_MAX,C_MAX,C_MAX, C_MIN,C_MIN,C_MAX},
        1'b0, deg0},
      // one-LSB geometry
      '{'{0,0,0, 1,0,0, 1,1,0, 1,1,1}, 1'b0, deg0},
      '{'{0,0,0, 1,0,0, 1,1,0, 1,1,-1}, 1'b0, deg0},
      // alternating bit patterns
      '{'{349525,-349526,349525, -349526,349525,-349526, 349525,349525,-349526,
          -349526,-349526,349525}, 1'b0, deg0}
    };
    limits = '{32'hFFFF_FFFF, 32'h0010_0000, $urandom, 32'h0000_0000, 32'h0000_0001};

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows run with the reset limit of 0
    foreach (rows[k]) begin
      foreach (c[i]) c[i] = coord_t'(rows[k].c[i]);
      send_quad(c);
      if (rows[k].typed) angle_due_q[$] = rows[k].res;
    end

    for (int ph = 0; ph <= 5; ph++) begin
      if (ph > 0) begin
        in_valid <= 1'b0;
        while (angle_due_q.size() != 0) @(posedge clk);
        limit_write(limits[ph - 1]);
        @(posedge clk);
      end
      for (int n = 0; n < 110; n++) begin
        if (n % 30 == 0) steady = ($urandom_range(0, 3) == 0);
        random_quad(c);
        send_quad(c);
      end
    end
    in_valid <= 1'b0;
    steady = 1'b0;

    while (angle_due_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (mismatches == 0 && angle_due_q.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
